[rtl/core/assert_macros.svh]
// assertion macros used by the rtl core module
// no dependencies; included by i2c_eeprom_master_core, the module that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/i2cem_pkg.sv]
// package for the i2c eeprom master: sizes, codes and the microcode rom
// no dependencies
package i2cem_pkg;

    localparam int PAGE_BYTES = 8;
    localparam int CNT_W      = $clog2(PAGE_BYTES + 1);
    localparam int BIDX_W     = $clog2(PAGE_BYTES + 3);
    localparam int PB_AW      = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    localparam logic [6:0]  DEV_ADDR_RST   = 7'd80;
    localparam logic [19:0] WRITE_WAIT_RST = 20'd10000;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic {
        REG_DEV_ADDR   = 1'b0,
        REG_WRITE_WAIT = 1'b1
    } t_reg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START,
        PH_W_LOW, PH_W_DATA, PH_W_HIGH,
        PH_A_LOW, PH_A_REL, PH_A_HIGH, PH_A_CHK,
        PH_RS_LOW, PH_RS_REL, PH_RS_HIGH, PH_RS_DRV,
        PH_R_LOW, PH_R_HIGH, PH_R_SMP,
        PH_M_LOW, PH_M_DRV, PH_M_HIGH, PH_M_LOW2, PH_M_REL,
        PH_N_LOW, PH_N_REL, PH_N_HIGH,
        PH_P_LOW, PH_P_DRV, PH_P_HIGH, PH_P_REL,
        PH_WAIT
    } t_phase;

    typedef enum logic [1:0] {
        SCL_KEEP, SCL_LO, SCL_HI
    } t_scl_op;

    typedef enum logic [1:0] {
        SDA_KEEP, SDA_LO, SDA_HI, SDA_BIT
    } t_sda_op;

    // how the step counter moves
    typedef enum logic [2:0] {
        J_HOLD,   // stay
        J_SEQ,    // go to the step in the word
        J_BIT,    // end of a sent bit
        J_ACK,    // slave ack check
        J_RS,     // repeated start, load read address byte
        J_SMP,    // sample a read bit
        J_STOP,   // end of stop
        J_WAIT    // write cycle wait
    } t_jump;

    typedef struct packed {
        t_scl_op scl;
        t_sda_op sda;
        t_jump   jmp;
        t_phase  next;
    } t_uword;

    function automatic t_uword ucode(t_phase p);
        t_uword w;
        w = '{scl: SCL_KEEP, sda: SDA_KEEP, jmp: J_HOLD, next: PH_IDLE};
        unique case (p)
            PH_IDLE:    w = '{SCL_KEEP, SDA_KEEP, J_HOLD, PH_IDLE};
            PH_START:   w = '{SCL_KEEP, SDA_LO,   J_SEQ,  PH_W_LOW};
            PH_W_LOW:   w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_W_DATA};
            PH_W_DATA:  w = '{SCL_KEEP, SDA_BIT,  J_SEQ,  PH_W_HIGH};
            PH_W_HIGH:  w = '{SCL_HI,   SDA_KEEP, J_BIT,  PH_W_LOW};
            PH_A_LOW:   w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_A_REL};
            PH_A_REL:   w = '{SCL_KEEP, SDA_HI,   J_SEQ,  PH_A_HIGH};
            PH_A_HIGH:  w = '{SCL_HI,   SDA_KEEP, J_SEQ,  PH_A_CHK};
            PH_A_CHK:   w = '{SCL_KEEP, SDA_KEEP, J_ACK,  PH_A_CHK};
            PH_RS_LOW:  w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_RS_REL};
            PH_RS_REL:  w = '{SCL_KEEP, SDA_HI,   J_SEQ,  PH_RS_HIGH};
            PH_RS_HIGH: w = '{SCL_HI,   SDA_KEEP, J_SEQ,  PH_RS_DRV};
            PH_RS_DRV:  w = '{SCL_KEEP, SDA_LO,   J_RS,   PH_W_LOW};
            PH_R_LOW:   w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_R_HIGH};
            PH_R_HIGH:  w = '{SCL_HI,   SDA_KEEP, J_SEQ,  PH_R_SMP};
            PH_R_SMP:   w = '{SCL_KEEP, SDA_KEEP, J_SMP,  PH_R_LOW};
            PH_M_LOW:   w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_M_DRV};
            PH_M_DRV:   w = '{SCL_KEEP, SDA_LO,   J_SEQ,  PH_M_HIGH};
            PH_M_HIGH:  w = '{SCL_HI,   SDA_KEEP, J_SEQ,  PH_M_LOW2};
            PH_M_LOW2:  w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_M_REL};
            PH_M_REL:   w = '{SCL_KEEP, SDA_HI,   J_SEQ,  PH_R_LOW};
            PH_N_LOW:   w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_N_REL};
            PH_N_REL:   w = '{SCL_KEEP, SDA_HI,   J_SEQ,  PH_N_HIGH};
            PH_N_HIGH:  w = '{SCL_HI,   SDA_KEEP, J_SEQ,  PH_P_LOW};
            PH_P_LOW:   w = '{SCL_LO,   SDA_KEEP, J_SEQ,  PH_P_DRV};
            PH_P_DRV:   w = '{SCL_KEEP, SDA_LO,   J_SEQ,  PH_P_HIGH};
            PH_P_HIGH:  w = '{SCL_HI,   SDA_KEEP, J_SEQ,  PH_P_REL};
            PH_P_REL:   w = '{SCL_KEEP, SDA_HI,   J_STOP, PH_IDLE};
            PH_WAIT:    w = '{SCL_KEEP, SDA_KEEP, J_WAIT, PH_IDLE};
            default:    w = '{SCL_KEEP, SDA_KEEP, J_HOLD, PH_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/i2c_eeprom_master_core.sv]
// i2c eeprom master: an accepted item is captured, executed, then reported by
// result strobe o_valid from the result register; no new item is taken while
// one executes; a single microcode step per item (fetch item, then execute one
// rom word); busy is high in the execute cycle only; results cannot be stalled
// synchronous active-low reset: bus idle, lines released, registers at reset
// values; the page buffer holds no reset and is only used below its fill count
`include "assert_macros.svh"

module i2c_eeprom_master_core
    import i2cem_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_mem_address,
    input  logic [7:0]  i_write_byte,
    input  logic [3:0]  i_byte_count,
    input  logic        i_sda_in,
    // result channel
    output logic        o_valid,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_read_last,
    output logic        o_busy_res,
    output logic        o_done_res,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [6:0]  r_dev_addr;
    logic [19:0] r_write_wait;
    logic        cfg_wr;
    t_reg        cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= DEV_ADDR_RST;
            r_write_wait <= WRITE_WAIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_DEV_ADDR:   r_dev_addr   <= pwdata[6:0];
                REG_WRITE_WAIT: r_write_wait <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_DEV_ADDR:   prdata = {25'd0, r_dev_addr};
            REG_WRITE_WAIT: prdata = {12'd0, r_write_wait};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // item capture: an accepted item is registered, then goes to execution
    // ---------------------------------------------------------------
    logic        r_busy;
    t_mode       r_mode;
    logic [7:0]  r_mem;
    logic [7:0]  r_wbyte;
    logic [3:0]  r_count;
    logic        r_sda_in;
    logic        accept;

    assign busy   = r_busy;
    assign accept = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= t_mode'(i_mode);
            r_mem    <= i_mem_address;
            r_wbyte  <= i_write_byte;
            r_count  <= i_byte_count;
            r_sda_in <= i_sda_in;
        end
    end

    // ---------------------------------------------------------------
    // sequencer state; r_phase is the microcode step counter
    // ---------------------------------------------------------------
    t_phase              r_phase,     n_phase;
    logic [2:0]          r_bit_idx,   n_bit_idx;
    logic [BIDX_W-1:0]   r_byte_idx,  n_byte_idx;
    logic [7:0]          r_shift,     n_shift;
    logic [CNT_W-1:0]    r_loaded,    n_loaded;
    logic [CNT_W-1:0]    r_total,     n_total;
    logic [7:0]          r_target,    n_target;
    logic [19:0]         r_wait,      n_wait;
    logic                r_op_read,   n_op_read;
    logic                r_scl,       n_scl;
    logic                r_sda,       n_sda;

    // page buffer, written only while idle, read one step ahead
    logic [7:0]          page_buffer [PAGE_BYTES];
    logic [7:0]          r_pb_rd;
    logic [BIDX_W-1:0]   pb_idx;
    logic [PB_AW-1:0]    pb_addr;
    logic                pb_wr;

    t_uword              uw;
    logic [BIDX_W-1:0]   byte_idx_inc;
    logic [7:0]          shift_in;
    logic [CNT_W-1:0]    cnt_sat;
    logic                is_tick;
    logic                is_idle;

    assign uw           = ucode(r_phase);
    assign byte_idx_inc = r_byte_idx + BIDX_W'(1);
    assign shift_in     = {r_shift[6:0], r_sda_in};
    assign is_tick      = (r_mode == MODE_TICK);
    assign is_idle      = (r_phase == PH_IDLE);

    // data byte d = acked count - 2 = current count - 1
    assign pb_idx  = r_byte_idx - BIDX_W'(1);
    assign pb_addr = pb_idx[PB_AW-1:0];
    assign pb_wr   = r_busy & ~is_tick & is_idle & (r_mode == MODE_LOAD) &
                     (r_loaded < CNT_W'(PAGE_BYTES));

    always_ff @(posedge i_clk) begin
        if (pb_wr) begin
            page_buffer[r_loaded[PB_AW-1:0]] <= r_wbyte;
        end
        r_pb_rd <= page_buffer[pb_addr];
    end

    // read count: zero taken as one, large counts saturate
    always_comb begin
        if (r_count == 4'd0) begin
            cnt_sat = CNT_W'(1);
        end else if (int'(r_count) > PAGE_BYTES) begin
            cnt_sat = CNT_W'(PAGE_BYTES);
        end else begin
            cnt_sat = CNT_W'(r_count);
        end
    end

    // next state: command decode or one microcode word
    always_comb begin
        n_phase    = r_phase;
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        n_shift    = r_shift;
        n_loaded   = r_loaded;
        n_total    = r_total;
        n_target   = r_target;
        n_wait     = r_wait;
        n_op_read  = r_op_read;
        n_scl      = r_scl;
        n_sda      = r_sda;

        if (!is_tick) begin
            if (is_idle) begin
                priority case (r_mode)
                    MODE_LOAD: begin
                        if (r_loaded < CNT_W'(PAGE_BYTES)) begin
                            n_loaded = r_loaded + CNT_W'(1);
                        end
                    end
                    default: begin
                        // write or read start, address byte goes out first
                        n_op_read  = (r_mode == MODE_READ);
                        n_total    = cnt_sat;
                        n_target   = r_mem;
                        n_byte_idx = '0;
                        n_shift    = {r_dev_addr, 1'b0};
                        n_bit_idx  = '0;
                        n_phase    = PH_START;
                    end
                endcase
            end
        end else begin
            unique case (uw.scl)
                SCL_LO:  n_scl = 1'b0;
                SCL_HI:  n_scl = 1'b1;
                default: n_scl = r_scl;
            endcase
            unique case (uw.sda)
                SDA_LO:  n_sda = 1'b0;
                SDA_HI:  n_sda = 1'b1;
                SDA_BIT: n_sda = r_shift[3'd7 - r_bit_idx];
                default: n_sda = r_sda;
            endcase

            unique case (uw.jmp)
                J_SEQ: n_phase = uw.next;
                J_BIT: begin
                    if (r_bit_idx == 3'd7) begin
                        n_bit_idx = '0;
                        n_phase   = PH_A_LOW;
                    end else begin
                        n_bit_idx = r_bit_idx + 3'd1;
                        n_phase   = PH_W_LOW;
                    end
                end
                J_ACK: begin
                    // no ack keeps the sequencer parked here
                    if (!r_sda_in) begin
                        n_byte_idx = byte_idx_inc;
                        if (byte_idx_inc == BIDX_W'(1)) begin
                            n_shift   = r_target;
                            n_bit_idx = '0;
                            n_phase   = PH_W_LOW;
                        end else if (!r_op_read) begin
                            if (byte_idx_inc < BIDX_W'(r_loaded) + BIDX_W'(2)) begin
                                n_shift   = r_pb_rd;
                                n_bit_idx = '0;
                                n_phase   = PH_W_LOW;
                            end else begin
                                n_phase = PH_P_LOW;
                            end
                        end else if (byte_idx_inc == BIDX_W'(2)) begin
                            n_phase = PH_RS_LOW;
                        end else begin
                            n_byte_idx = '0;
                            n_bit_idx  = '0;
                            n_shift    = '0;
                            n_phase    = PH_R_LOW;
                        end
                    end
                end
                J_RS: begin
                    n_shift   = {r_dev_addr, 1'b1};
                    n_bit_idx = '0;
                    n_phase   = PH_W_LOW;
                end
                J_SMP: begin
                    if (r_bit_idx == 3'd7) begin
                        n_bit_idx  = '0;
                        n_byte_idx = byte_idx_inc;
                        n_shift    = '0;
                        n_phase    = (byte_idx_inc >= BIDX_W'(r_total)) ? PH_N_LOW
                                                                        : PH_M_LOW;
                    end else begin
                        n_shift   = shift_in;
                        n_bit_idx = r_bit_idx + 3'd1;
                        n_phase   = PH_R_LOW;
                    end
                end
                J_STOP: begin
                    if (!r_op_read) begin
                        n_loaded = '0;
                    end
                    if (!r_op_read && (r_write_wait != 20'd0)) begin
                        n_wait  = r_write_wait;
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                J_WAIT: begin
                    if (r_wait != 20'd0) begin
                        n_wait = r_wait - 20'd1;
                    end
                    if (r_wait <= 20'd1) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // result fields of this item
    logic       n_read_valid;
    logic [7:0] n_read_byte;
    logic       n_read_last;
    logic       n_done;

    always_comb begin
        n_read_valid = 1'b0;
        n_read_byte  = '0;
        n_read_last  = 1'b0;
        n_done       = 1'b0;
        if (is_tick) begin
            if ((uw.jmp == J_SMP) && (r_bit_idx == 3'd7)) begin
                n_read_valid = 1'b1;
                n_read_byte  = shift_in;
                n_read_last  = (byte_idx_inc >= BIDX_W'(r_total));
            end
            if ((uw.jmp == J_STOP) && (r_op_read || (r_write_wait == 20'd0))) begin
                n_done = 1'b1;
            end
            if ((uw.jmp == J_WAIT) && (r_wait <= 20'd1)) begin
                n_done = 1'b1;
            end
        end
    end

    // state update in the execute cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_idx  <= '0;
            r_byte_idx <= '0;
            r_shift    <= '0;
            r_loaded   <= '0;
            r_total    <= '0;
            r_target   <= '0;
            r_wait     <= '0;
            r_op_read  <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
        end else if (r_busy) begin
            r_phase    <= n_phase;
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
            r_shift    <= n_shift;
            r_loaded   <= n_loaded;
            r_total    <= n_total;
            r_target   <= n_target;
            r_wait     <= n_wait;
            r_op_read  <= n_op_read;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
        end
    end

    // ---------------------------------------------------------------
    // result register: strobe for one cycle after execution
    // ---------------------------------------------------------------
    logic       r_valid;
    logic       r_read_valid;
    logic [7:0] r_read_byte;
    logic       r_read_last;
    logic       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_read_valid <= n_read_valid;
            r_read_byte  <= n_read_byte;
            r_read_last  <= n_read_last;
            r_done       <= n_done;
        end
    end

    assign o_valid      = r_valid;
    assign o_scl_level  = r_scl;
    assign o_sda_level  = r_sda;
    assign o_read_valid = r_read_valid;
    assign o_read_byte  = r_read_byte;
    assign o_read_last  = r_read_last;
    assign o_busy_res   = ~is_idle;
    assign o_done_res   = r_done;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `ASSERT_NEXT(a_exec_then_strobe, i_clk, i_rst_n, r_busy, o_valid, "no strobe after execute")
    `ASSERT_IMPLY(a_strobe_not_busy, i_clk, i_rst_n, o_valid, !r_busy, "strobe while executing")
    `ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_valid && o_done_res, is_idle, "done while active")
    `ASSERT_IMPLY(a_load_bound, i_clk, i_rst_n, 1'b1, r_loaded <= CNT_W'(PAGE_BYTES), "fill overrun")

endmodule

[tb/testbench.sv]
// testbench for the i2c eeprom master core: a step-by-step model of the bus
// sequencer predicts the line levels and read bytes of every item
// depends on i2cem_pkg and i2c_eeprom_master_core only
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cem_pkg::*;

    // one command or bus tick, as driven on the command channel
    typedef struct packed {
        t_mode      mode;
        logic [7:0] mem;
        logic [7:0] wbyte;
        logic [3:0] count;
        logic       sda;
    } t_cmd;

    // line levels and read data reported for one item
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       rvalid;
        logic [7:0] rbyte;
        logic       rlast;
        logic       busy;
        logic       done;
    } t_lines;

    // a row of the directed table either drives one item or ticks the
    // current transfer through to its end
    typedef enum logic {
        ROW_ITEM,
        ROW_FINISH
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_cmd       cmd;
        logic [3:0] stall;
        logic       typed;
        t_lines     want;
    } t_row;

    localparam t_lines LN_IDLE    = '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
    localparam t_lines LN_HELD    = '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
    localparam t_lines LN_SDA_LO  = '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
    localparam t_lines LN_BOTH_LO = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
    localparam t_cmd   NO_CMD     = '{MODE_TICK, 8'h00, 8'h00, 4'd0, 1'b0};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [7:0]  i_mem_address;
    logic [7:0]  i_write_byte;
    logic [3:0]  i_byte_count;
    logic        i_sda_in;
    logic        o_valid;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_read_valid;
    logic [7:0]  o_read_byte;
    logic        o_read_last;
    logic        o_busy_res;
    logic        o_done_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2c_eeprom_master_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_mem_address (i_mem_address),
        .i_write_byte  (i_write_byte),
        .i_byte_count  (i_byte_count),
        .i_sda_in      (i_sda_in),
        .o_valid       (o_valid),
        .o_scl_level   (o_scl_level),
        .o_sda_level   (o_sda_level),
        .o_read_valid  (o_read_valid),
        .o_read_byte   (o_read_byte),
        .o_read_last   (o_read_last),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer model: register copies and bus state
    // ------------------------------------------------------------------
    logic [6:0]  dev_addr   = DEV_ADDR_RST;
    logic [19:0] wait_ticks = WRITE_WAIT_RST;

    t_phase      ph = PH_IDLE;
    int          bit_n;
    int          byte_n;
    logic [7:0]  sh;
    logic [7:0]  page [PAGE_BYTES];
    int          fill;
    logic [7:0]  target;
    logic [19:0] wait_left;
    logic        reading;
    int          total;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;

    t_lines      pending_lines [$];   // line levels still owed by the core
    int          idle_pct;            // chance in 100 that the sender pauses
    int          work_items;          // items that moved the sequencer
    int          errors;

    // next byte to shift out, msb first
    function automatic void queue_byte(input logic [7:0] b);
        sh = b;
        bit_n = 0;
        ph = PH_W_LOW;
    endfunction

    // advance the sequencer by one item and return the levels it reports
    function automatic t_lines step_sequencer(input t_cmd c);
        t_lines r;
        int cnt;
        int d;
        r = '0;
        if (c.mode != MODE_TICK) begin
            // commands only count while idle and never move the lines
            if (ph == PH_IDLE) begin
                if (c.mode == MODE_LOAD) begin
                    if (fill < PAGE_BYTES) begin
                        page[fill] = c.wbyte;
                        fill++;
                    end
                end else begin
                    reading = (c.mode == MODE_READ);
                    cnt = (c.count == 4'd0) ? 1 : int'(c.count);
                    if (cnt > PAGE_BYTES)
                        cnt = PAGE_BYTES;
                    total = cnt;
                    target = c.mem;
                    byte_n = 0;
                    sh = {dev_addr, 1'b0};
                    bit_n = 0;
                    ph = PH_START;
                end
            end
        end else begin
            case (ph)
                PH_START: begin sda_q = 1'b0; ph = PH_W_LOW; end
                PH_W_LOW: begin scl_q = 1'b0; ph = PH_W_DATA; end
                PH_W_DATA: begin
                    sda_q = sh[7 - bit_n];
                    ph = PH_W_HIGH;
                end
                PH_W_HIGH: begin
                    scl_q = 1'b1;
                    bit_n++;
                    if (bit_n >= 8) begin
                        bit_n = 0;
                        ph = PH_A_LOW;
                    end else begin
                        ph = PH_W_LOW;
                    end
                end
                PH_A_LOW: begin scl_q = 1'b0; ph = PH_A_REL; end
                PH_A_REL: begin sda_q = 1'b1; ph = PH_A_HIGH; end
                PH_A_HIGH: begin scl_q = 1'b1; ph = PH_A_CHK; end
                PH_A_CHK: begin
                    // sda high here means no ack: hold until it comes
                    if (!c.sda) begin
                        byte_n++;
                        if (byte_n == 1) begin
                            queue_byte(target);
                        end else if (!reading) begin
                            d = byte_n - 2;
                            if (d < fill && d < PAGE_BYTES)
                                queue_byte(page[d]);
                            else
                                ph = PH_P_LOW;
                        end else if (byte_n == 2) begin
                            ph = PH_RS_LOW;
                        end else begin
                            byte_n = 0;
                            bit_n = 0;
                            sh = 8'h00;
                            ph = PH_R_LOW;
                        end
                    end
                end
                PH_RS_LOW: begin scl_q = 1'b0; ph = PH_RS_REL; end
                PH_RS_REL: begin sda_q = 1'b1; ph = PH_RS_HIGH; end
                PH_RS_HIGH: begin scl_q = 1'b1; ph = PH_RS_DRV; end
                PH_RS_DRV: begin
                    sda_q = 1'b0;
                    queue_byte({dev_addr, 1'b1});
                end
                PH_R_LOW: begin scl_q = 1'b0; ph = PH_R_HIGH; end
                PH_R_HIGH: begin scl_q = 1'b1; ph = PH_R_SMP; end
                PH_R_SMP: begin
                    sh = {sh[6:0], c.sda};
                    bit_n++;
                    if (bit_n >= 8) begin
                        bit_n = 0;
                        byte_n++;
                        r.rvalid = 1'b1;
                        r.rbyte = sh;
                        r.rlast = (byte_n >= total);
                        sh = 8'h00;
                        ph = r.rlast ? PH_N_LOW : PH_M_LOW;
                    end else begin
                        ph = PH_R_LOW;
                    end
                end
                PH_M_LOW: begin scl_q = 1'b0; ph = PH_M_DRV; end
                PH_M_DRV: begin sda_q = 1'b0; ph = PH_M_HIGH; end
                PH_M_HIGH: begin scl_q = 1'b1; ph = PH_M_LOW2; end
                PH_M_LOW2: begin scl_q = 1'b0; ph = PH_M_REL; end
                PH_M_REL: begin sda_q = 1'b1; ph = PH_R_LOW; end
                PH_N_LOW: begin scl_q = 1'b0; ph = PH_N_REL; end
                PH_N_REL: begin sda_q = 1'b1; ph = PH_N_HIGH; end
                PH_N_HIGH: begin scl_q = 1'b1; ph = PH_P_LOW; end
                PH_P_LOW: begin scl_q = 1'b0; ph = PH_P_DRV; end
                PH_P_DRV: begin sda_q = 1'b0; ph = PH_P_HIGH; end
                PH_P_HIGH: begin scl_q = 1'b1; ph = PH_P_REL; end
                PH_P_REL: begin
                    // end of stop: a write clears the buffer and waits out
                    // the eeprom cycle unless the wait is zero
                    sda_q = 1'b1;
                    if (!reading)
                        fill = 0;
                    if (!reading && wait_ticks != 20'd0) begin
                        wait_left = wait_ticks;
                        ph = PH_WAIT;
                    end else begin
                        ph = PH_IDLE;
                        r.done = 1'b1;
                    end
                end
                PH_WAIT: begin
                    if (wait_left != 20'd0)
                        wait_left--;
                    if (wait_left == 20'd0) begin
                        ph = PH_IDLE;
                        r.done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.scl = scl_q;
        r.sda = sda_q;
        r.busy = (ph != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result check: every strobe is matched against the oldest item
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_lines want;
        if (i_rst_n && o_valid) begin
            if (pending_lines.size() == 0) begin
                $error("result strobe with no item outstanding");
                errors++;
            end else begin
                want = pending_lines.pop_front();
                check_field("scl_level", 8'(want.scl), 8'(o_scl_level));
                check_field("sda_level", 8'(want.sda), 8'(o_sda_level));
                check_field("read_valid", 8'(want.rvalid), 8'(o_read_valid));
                check_field("read_byte", want.rbyte, o_read_byte);
                check_field("read_last", 8'(want.rlast), 8'(o_read_last));
                check_field("busy_res", 8'(want.busy), 8'(o_busy_res));
                check_field("done_res", 8'(want.done), 8'(o_done_res));
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // random fields around a chosen mode
    function automatic t_cmd noise_cmd(input t_mode m);
        t_cmd c;
        c.mode = m;
        c.mem = 8'($urandom);
        c.wbyte = 8'($urandom);
        c.count = 4'($urandom);
        c.sda = 1'($urandom);
        return c;
    endfunction

    // present one item, wait until the core takes it, then log what it owes;
    // start is left high between back-to-back items
    task automatic issue(input t_cmd c, input logic typed = 1'b0,
                         input t_lines want = '0);
        t_lines got_pred;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= c.mode;
        i_mem_address <= c.mem;
        i_write_byte <= c.wbyte;
        i_byte_count <= c.count;
        i_sda_in <= c.sda;
        do @(posedge i_clk); while (busy);
        if (c.mode == MODE_TICK ? (ph != PH_IDLE) : (ph == PH_IDLE))
            work_items++;
        got_pred = step_sequencer(c);
        pending_lines.push_back(typed ? want : got_pred);
    endtask

    // hold off until every owed item has come back
    task automatic settle();
        start <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic reg_write(input t_reg r, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (r == REG_DEV_ADDR)
            dev_addr = v[6:0];
        else
            wait_ticks = v[19:0];
    endtask

    // tick the running transfer to idle; the slave acks most of the time,
    // the first stall ack checks are held off, and noisy runs slip in
    // commands that the core must ignore
    task automatic run_transfer(input int stall, input logic noisy);
        t_cmd c;
        while (ph != PH_IDLE) begin
            c = noise_cmd(MODE_TICK);
            if (ph == PH_A_CHK) begin
                if (stall > 0) begin
                    c.sda = 1'b1;
                    stall--;
                end else begin
                    c.sda = ($urandom_range(9) == 0);
                end
            end
            if (noisy && $urandom_range(19) == 0)
                c.mode = t_mode'($urandom_range(1, 3));
            issue(c);
        end
    endtask

    // idle ticks, page loads, then mostly a write or read run to the end
    task automatic random_transfer(input logic reads_only);
        t_cmd c;
        int n;
        repeat ($urandom_range(0, 2)) issue(noise_cmd(MODE_TICK));
        if ($urandom_range(4) == 0)
            n = $urandom_range(0, PAGE_BYTES + 2);
        else
            n = $urandom_range(0, 3);
        repeat (n) issue(noise_cmd(MODE_LOAD));
        // now and then the loads are left for a later transfer
        if ($urandom_range(7) == 0)
            return;
        c = noise_cmd(MODE_WRITE);
        if (reads_only || $urandom_range(1) == 1)
            c.mode = MODE_READ;
        if ($urandom_range(3) == 0)
            c.count = 4'($urandom_range(15));
        else
            c.count = 4'($urandom_range(1, 3));
        case ($urandom_range(7))
            0: c.mem = 8'h00;
            1: c.mem = 8'hFF;
            default: ;
        endcase
        issue(c);
        run_transfer(0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // directed table, run with a zero write wait and the reset address
    // ------------------------------------------------------------------
    t_row plan [24] = '{
        '{ROW_ITEM,   '{MODE_TICK,  8'h00, 8'h00, 4'd0,  1'b1}, 4'd0, 1'b1, LN_IDLE},
        // read count zero is taken as one byte
        '{ROW_ITEM,   '{MODE_READ,  8'hFF, 8'h00, 4'd0,  1'b0}, 4'd0, 1'b1, LN_HELD},
        // commands while busy change nothing
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'h12, 4'd1,  1'b0}, 4'd0, 1'b1, LN_HELD},
        '{ROW_ITEM,   '{MODE_TICK,  8'h00, 8'h00, 4'd0,  1'b1}, 4'd0, 1'b1, LN_SDA_LO},
        '{ROW_ITEM,   '{MODE_WRITE, 8'h33, 8'h00, 4'd8,  1'b0}, 4'd0, 1'b1, LN_SDA_LO},
        '{ROW_ITEM,   '{MODE_TICK,  8'h00, 8'h00, 4'd0,  1'b0}, 4'd0, 1'b1, LN_BOTH_LO},
        // slave holds off its first ack for three ticks
        '{ROW_FINISH, NO_CMD,                                 4'd3, 1'b0, LN_IDLE},
        // count above the page size saturates
        '{ROW_ITEM,   '{MODE_READ,  8'h00, 8'h00, 4'd15, 1'b1}, 4'd0, 1'b1, LN_HELD},
        '{ROW_FINISH, NO_CMD,                                 4'd0, 1'b0, LN_IDLE},
        // write with an empty buffer sends only the two address bytes
        '{ROW_ITEM,   '{MODE_WRITE, 8'h5A, 8'hFF, 4'd0,  1'b0}, 4'd0, 1'b1, LN_HELD},
        '{ROW_FINISH, NO_CMD,                                 4'd0, 1'b0, LN_IDLE},
        // fill the page, then one more byte that must be dropped
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'hFF, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'hFF, 8'h00, 4'd15, 1'b1}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'h01, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'h80, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'h55, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'hAA, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'h7F, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'hFE, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_LOAD,  8'h00, 8'h33, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        // full page write, done on the tick that ends the stop
        '{ROW_ITEM,   '{MODE_WRITE, 8'hFF, 8'h00, 4'd15, 1'b0}, 4'd0, 1'b1, LN_HELD},
        '{ROW_FINISH, NO_CMD,                                 4'd1, 1'b0, LN_IDLE},
        '{ROW_ITEM,   '{MODE_TICK,  8'h00, 8'h00, 4'd0,  1'b0}, 4'd0, 1'b1, LN_IDLE},
        '{ROW_ITEM,   '{MODE_TICK,  8'hFF, 8'hFF, 4'd15, 1'b1}, 4'd0, 1'b1, LN_IDLE}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic paused;
        start <= 1'b0;
        i_mode <= MODE_TICK;
        i_mem_address <= 8'h00;
        i_write_byte <= 8'h00;
        i_byte_count <= 4'd0;
        i_sda_in <= 1'b1;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        errors = 0;
        idle_pct = 0;
        paused = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with no write wait and no sender gaps
        reg_write(REG_WRITE_WAIT, 32'd0);
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_FINISH)
                run_transfer(int'(plan[k].stall), 1'b0);
            else
                issue(plan[k].cmd, plan[k].typed, plan[k].want);
        end

        // top address, one-tick write wait, sender often idle
        settle();
        reg_write(REG_DEV_ADDR, 32'd127);
        reg_write(REG_WRITE_WAIT, 32'd1);
        idle_pct = 57;
        work_items = 0;
        while (work_items < 150)
            random_transfer(1'b0);

        // address zero and the longest write wait; only reads can finish
        // in reasonable time here, so no write is started
        settle();
        reg_write(REG_DEV_ADDR, 32'd0);
        reg_write(REG_WRITE_WAIT, 32'hFFFFF);
        idle_pct = 0;
        work_items = 0;
        while (work_items < 100)
            random_transfer(1'b1);

        // random address and short waits, light gaps, one full drain midway
        settle();
        reg_write(REG_DEV_ADDR, 32'($urandom_range(127)));
        reg_write(REG_WRITE_WAIT, 32'($urandom_range(2, 40)));
        idle_pct = 20;
        work_items = 0;
        while (work_items < 150) begin
            random_transfer(1'b0);
            if (!paused && work_items >= 75) begin
                settle();
                paused = 1'b1;
            end
        end

        settle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
